>>> sv/aes_ctr_pkg.sv
// Package: shared types, constants and AES functions for the CTR keystream core.
package aes_ctr_pkg;

   localparam int unsigned RoundCount = 10;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned WordWidth = 64;
   localparam int unsigned BlockWidth = 128;
   localparam int unsigned RoundWidth = 4;

   localparam logic [CsrIndexWidth-1:0] CsrKeyHigh = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrKeyLow = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrNonce = 2'd2;

   typedef struct packed {
      logic [BlockWidth-1:0] ctr_block;
      logic [BlockWidth-1:0] data;
   } job_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [RoundWidth-1:0] r);
      logic [7:0] v;
      unique case (r)
         4'd1: v = 8'h01;
         4'd2: v = 8'h02;
         4'd3: v = 8'h04;
         4'd4: v = 8'h08;
         4'd5: v = 8'h10;
         4'd6: v = 8'h20;
         4'd7: v = 8'h40;
         4'd8: v = 8'h80;
         4'd9: v = 8'h1b;
         4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // byte i of a block sits at bits 127-8i down to 120-8i
   function automatic logic [7:0] get_byte(input logic [BlockWidth-1:0] b, input int i);
      return b[BlockWidth-1-8*i -: 8];
   endfunction

   function automatic logic [BlockWidth-1:0] next_round_key(
      input logic [BlockWidth-1:0] k, input logic [RoundWidth-1:0] r);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rcon(r), SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [BlockWidth-1:0] aes_round(
      input logic [BlockWidth-1:0] s, input logic last);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [BlockWidth-1:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[i + 4*c] = SBOX[get_byte(s, i + 4*((c + i) % 4))];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c];
         a1 = t[4*c+1];
         a2 = t[4*c+2];
         a3 = t[4*c+3];
         al = a0 ^ a1 ^ a2 ^ a3;
         if (!last) begin
            a0 = t[4*c] ^ al ^ xtime(t[4*c] ^ t[4*c+1]);
            a1 = t[4*c+1] ^ al ^ xtime(t[4*c+1] ^ t[4*c+2]);
            a2 = t[4*c+2] ^ al ^ xtime(t[4*c+2] ^ t[4*c+3]);
            a3 = t[4*c+3] ^ al ^ xtime(t[4*c+3] ^ t[4*c]);
         end
         o[BlockWidth-1-32*c -: 32] = {a0, a1, a2, a3};
      end
      return o;
   endfunction

endpackage

>>> sv/aes_ctr_if.sv
// Interfaces: valid/ready channels for data blocks and results.
interface aes_ctr_req_if;
   logic valid;
   logic ready;
   logic first_block;
   logic [63:0] data_high;
   logic [63:0] data_low;
   modport source(output valid, first_block, data_high, data_low, input ready);
   modport sink(input valid, first_block, data_high, data_low, output ready);
endinterface

interface aes_ctr_rsp_if;
   logic valid;
   logic ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   modport source(output valid, result_high, result_low, input ready);
   modport sink(input valid, result_high, result_low, output ready);
endinterface

>>> sv/aes_ctr_front.sv
// Front end: counter tracking, counter block build and two-entry job queue.
module aes_ctr_front (
   input  logic clock,
   input  logic reset,
   input  logic [63:0] nonce,
   aes_ctr_req_if.sink req,
   output logic job_valid,
   input  logic job_ready,
   output aes_ctr_pkg::job_type job
);
   logic [63:0] counter_ff, counter_in, ctr;
   aes_ctr_pkg::job_type q_ff [2];
   logic rd_ff, wr_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_ready;
   assign job = q_ff[rd_ff];
   assign ctr = req.first_block ? 64'd1 : counter_ff;
   assign counter_in = ctr + 64'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= 64'd1;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            counter_ff <= counter_in;
            wr_ff <= ~wr_ff;
         end
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= '{ctr_block: {nonce, ctr}, data: {req.data_high, req.data_low}};
      end
   end
endmodule

>>> sv/aes_ctr_back.sv
// Back end: iterative AES-128 round unit with on-the-fly key schedule and output register.
module aes_ctr_back (
   input  logic clock,
   input  logic reset,
   input  logic [127:0] key,
   input  logic job_valid,
   output logic job_ready,
   input  aes_ctr_pkg::job_type job,
   aes_ctr_rsp_if.source rsp
);
   typedef enum logic [1:0] {
      IDLE = 2'b01,
      RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [aes_ctr_pkg::RoundWidth-1:0] round_ff, round_in;
   logic [127:0] st_ff, st_in, rk_ff, rk_in, data_ff, nk, rs;
   logic [127:0] res_ff;
   logic rv_ff;
   logic last, done;

   assign last = (round_ff == aes_ctr_pkg::RoundWidth'(aes_ctr_pkg::RoundCount));
   assign nk = aes_ctr_pkg::next_round_key(rk_ff, round_ff);
   assign rs = aes_ctr_pkg::aes_round(st_ff, last) ^ nk;
   assign done = (state_ff == RUN) && last && (!rv_ff || rsp.ready);
   assign job_ready = (state_ff == IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.result_high = res_ff[127:64];
   assign rsp.result_low = res_ff[63:0];

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      st_in = st_ff;
      rk_in = rk_ff;
      unique case (state_ff)
         IDLE: begin
            if (job_valid) begin
               st_in = job.ctr_block ^ key;
               rk_in = key;
               round_in = 4'd1;
               state_in = RUN;
            end
         end
         RUN: begin
            if (!last) begin
               st_in = rs;
               rk_in = nk;
               round_in = round_ff + 4'd1;
            end else if (done) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (done) rv_ff <= 1'b1;
         else if (rsp.ready) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      st_ff <= st_in;
      rk_ff <= rk_in;
      if (job_valid && job_ready) data_ff <= job.data;
      if (done) res_ff <= rs ^ data_ff;
   end
endmodule

>>> sv/aes128_ctr_keystream_xor_core.sv
// Top level: AES-128 CTR keystream XOR core with configuration registers.
// Usage:
//   req channel carries first_block, data_high, data_low (one 16-byte block).
//   rsp channel returns result_high, result_low = data XOR AES(key, nonce||ctr).
//   csr port writes key_high (0), key_low (1), nonce (2); other indexes ignored.
//   The counter is 1 for a block marked first, else the previous counter + 1.
// Timing:
//   One AES round per cycle in a single round unit with the key schedule
//   computed alongside, the last round waiting while the result register is full;
//   a block goes from queue head to result register through a load and then ten
//   rounds, and the round unit takes no new block until the last one is done.
//   A req transaction reaches rsp valid via queue, load, rounds and result register.
//   A two-entry queue separates counter handling from the round unit.
// Reset:
//   Key and nonce clear to zero, counter to 1, queue and result empty.
// Stall:
//   If rsp is held, the result register holds its transaction; the round unit
//   waits on its last round and the queue fills before req.ready drops.
module aes128_ctr_keystream_xor_core (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [aes_ctr_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [aes_ctr_pkg::WordWidth-1:0] csr_wdata,
   aes_ctr_req_if.sink req,
   aes_ctr_rsp_if.source rsp
);
   logic [63:0] key_high_ff, key_low_ff, nonce_ff;
   logic job_valid, job_ready;
   aes_ctr_pkg::job_type job;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
         nonce_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            aes_ctr_pkg::CsrKeyHigh: key_high_ff <= csr_wdata;
            aes_ctr_pkg::CsrKeyLow: key_low_ff <= csr_wdata;
            aes_ctr_pkg::CsrNonce: nonce_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   aes_ctr_front u_front (
      .clock(clock), .reset(reset), .nonce(nonce_ff), .req(req),
      .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   aes_ctr_back u_back (
      .clock(clock), .reset(reset), .key({key_high_ff, key_low_ff}),
      .job_valid(job_valid), .job_ready(job_ready), .job(job), .rsp(rsp)
   );
endmodule

>>> dv/aes128_ctr_keystream_xor_core_tb.sv
// Testbench: AES-128 CTR keystream XOR core checked against a behavioral predictor.
`timescale 1ns / 100ps

module aes128_ctr_keystream_xor_core_tb;

   typedef struct packed {
      logic        first_block;
      logic [63:0] data_high;
      logic [63:0] data_low;
   } block_item_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } xor_result_type;

   localparam int unsigned WatchdogLimit = 20000;
   localparam int unsigned DrainCycles = 40;
   localparam logic [aes_ctr_pkg::CsrIndexWidth-1:0] CsrBeyondList = 2'd3;

   localparam logic [7:0] SUB [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };
   localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                        8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [aes_ctr_pkg::CsrIndexWidth-1:0] csr_index = aes_ctr_pkg::CsrKeyHigh;
   logic [63:0] csr_wdata = '0;

   aes_ctr_req_if req ();
   aes_ctr_rsp_if rsp ();

   aes128_ctr_keystream_xor_core i_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req(req.sink), .rsp(rsp.source)
   );

   always #1 clock = ~clock;

   logic [63:0] mdl_key_high = '0;
   logic [63:0] mdl_key_low = '0;
   logic [63:0] mdl_nonce = '0;
   logic [63:0] mdl_counter = 64'd1;
   logic [7:0] round_keys [176];

   block_item_type pending_blocks [$];
   xor_result_type expected_results [$];
   int unsigned mismatches = 0;
   int unsigned blocks_sent = 0;
   int unsigned results_seen = 0;
   int unsigned quiet_cycles = 0;
   int unsigned idle_pct = 27;

   function automatic logic [7:0] gf_double(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   task automatic expand_round_keys();
      logic [7:0] t [4];
      logic [7:0] f;
      logic [127:0] k;
      k = {mdl_key_high, mdl_key_low};
      for (int i = 0; i < 16; i++) round_keys[i] = k[127-8*i -: 8];
      for (int i = 16; i < 176; i += 4) begin
         for (int j = 0; j < 4; j++) t[j] = round_keys[i-4+j];
         if (i % 16 == 0) begin
            f = t[0];
            t[0] = SUB[t[1]] ^ RCON[i/16-1];
            t[1] = SUB[t[2]];
            t[2] = SUB[t[3]];
            t[3] = SUB[f];
         end
         for (int j = 0; j < 4; j++) round_keys[i+j] = round_keys[i-16+j] ^ t[j];
      end
   endtask

   function automatic logic [127:0] keystream_block(input logic [63:0] ctr);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] blk, o;
      blk = {mdl_nonce, ctr};
      for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ round_keys[i];
      for (int r = 1; r <= 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) t[i+4*c] = SUB[s[i+4*((c+i)%4)]];
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (r != 10) begin
               s[4*c]   = a0 ^ al ^ gf_double(a0 ^ a1);
               s[4*c+1] = a1 ^ al ^ gf_double(a1 ^ a2);
               s[4*c+2] = a2 ^ al ^ gf_double(a2 ^ a3);
               s[4*c+3] = a3 ^ al ^ gf_double(a3 ^ a0);
            end else begin
               s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
            end
         end
         for (int i = 0; i < 16; i++) s[i] = s[i] ^ round_keys[16*r+i];
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
      return o;
   endfunction

   task automatic predict_xor(input block_item_type b);
      logic [63:0] ctr;
      logic [127:0] ks;
      xor_result_type exp_item;
      ctr = b.first_block ? 64'd1 : mdl_counter;
      mdl_counter = ctr + 64'd1;
      ks = keystream_block(ctr);
      exp_item = {b.data_high ^ ks[127:64], b.data_low ^ ks[63:0]};
      expected_results.insert(expected_results.size(), exp_item);
   endtask

   task automatic csr_write(input logic [aes_ctr_pkg::CsrIndexWidth-1:0] idx,
                            input logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      unique case (idx)
         aes_ctr_pkg::CsrKeyHigh: begin mdl_key_high = val; expand_round_keys(); end
         aes_ctr_pkg::CsrKeyLow: begin mdl_key_low = val; expand_round_keys(); end
         aes_ctr_pkg::CsrNonce: mdl_nonce = val;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_blocks.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.first_block <= 1'b0;
         req.data_high <= '0;
         req.data_low <= '0;
      end else begin
         if (req.valid && req.ready) begin
            predict_xor({req.first_block, req.data_high, req.data_low});
            void'(pending_blocks.pop_front());
            blocks_sent++;
         end
         if (pending_blocks.size() != 0 && (!(req.valid && !req.ready))
             && $urandom_range(99) >= idle_pct) begin
            req.valid <= 1'b1;
            {req.first_block, req.data_high, req.data_low} <= pending_blocks[0];
         end else if (!(req.valid && !req.ready)) begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      xor_result_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result %h %h", rsp.result_high, rsp.result_low);
            end else begin
               want = expected_results.pop_front();
               if (want.result_high !== rsp.result_high || want.result_low !== rsp.result_low) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h %h, got %h %h", want.result_high,
                              want.result_low, rsp.result_high, rsp.result_low);
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog expired");
            $display("aes128_ctr_keystream_xor_core_tb: done, errors");
            $finish;
         end
      end
   end

   task automatic queue_block(input logic first, input logic [63:0] hi, input logic [63:0] lo);
      block_item_type item;
      item = {first, hi, lo};
      pending_blocks.insert(pending_blocks.size(), item);
   endtask

   task automatic run_random(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         queue_block(($urandom_range(9) == 0), rand64(), rand64());
         if (n == count / 2) idle_pct = 0;
         if (n == count / 2 + count / 8) idle_pct = 27;
         while (pending_blocks.size() > 4) @(posedge clock);
      end
      wait_idle();
   endtask

   initial begin
      expand_round_keys();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // blocks after reset: all-zero key and nonce, counter starts at 1
      queue_block(1'b0, '0, '0);
      queue_block(1'b0, '1, '1);
      queue_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210);
      queue_block(1'b0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      queue_block(1'b1, '1, '0);
      wait_idle();

      csr_write(aes_ctr_pkg::CsrKeyHigh, 64'h2b7e151628aed2a6);
      csr_write(aes_ctr_pkg::CsrKeyLow, 64'habf7158809cf4f3c);
      csr_write(aes_ctr_pkg::CsrNonce, 64'hf0f1f2f3f4f5f6f7);
      csr_write(CsrBeyondList, rand64());
      queue_block(1'b1, 64'h6bc1bee22e409f96, 64'he93d7e117393172a);
      queue_block(1'b0, 64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51);
      queue_block(1'b0, '0, '1);
      wait_idle();

      // key and nonce change mid-message, counter keeps running
      csr_write(aes_ctr_pkg::CsrKeyLow, '1);
      queue_block(1'b0, '0, '0);
      wait_idle();
      csr_write(aes_ctr_pkg::CsrNonce, '1);
      queue_block(1'b0, '1, '0);
      wait_idle();
      csr_write(aes_ctr_pkg::CsrKeyHigh, '1);
      queue_block(1'b0, '0, '0);
      queue_block(1'b1, '0, '0);
      wait_idle();

      run_random(300);

      csr_write(aes_ctr_pkg::CsrKeyHigh, '0);
      csr_write(aes_ctr_pkg::CsrKeyLow, '0);
      csr_write(aes_ctr_pkg::CsrNonce, '0);
      run_random(200);

      csr_write(aes_ctr_pkg::CsrKeyHigh, rand64());
      csr_write(aes_ctr_pkg::CsrKeyLow, rand64());
      csr_write(aes_ctr_pkg::CsrNonce, rand64());
      run_random(300);

      $display("covered %0d blocks and %0d results over several key and nonce settings",
               blocks_sent, results_seen);
      if (mismatches == 0) begin
         $display("aes128_ctr_keystream_xor_core_tb: done, clean");
      end else begin
         $display("mismatches: %0d", mismatches);
         $display("aes128_ctr_keystream_xor_core_tb: done, errors");
      end
      $finish;
   end

endmodule
